// ----- rtl/psbf_pkg.sv -----
package psbf_pkg;

    // request codes carried on the input channel
    typedef enum logic [1:0] {
        REQ_BYTE      = 2'd0,
        REQ_ADDR_RULE = 2'd1,
        REQ_PORT_RULE = 2'd2
    } t_req;

    // result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    localparam int unsigned PORT_W     = 16;
    localparam int unsigned PORT_SPACE = 65536;
    localparam int unsigned ADDR_W     = 32;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // byte positions within the frame; OFS_DOFF is relative to the transport header
    localparam logic [7:0] POS_ETYPE_HI = 8'd12;
    localparam logic [7:0] POS_ETYPE_LO = 8'd13;
    localparam logic [7:0] POS_IHL      = 8'd14;
    localparam logic [7:0] POS_PROTO    = 8'd23;
    localparam logic [7:0] POS_SRC_0    = 8'd26;
    localparam logic [7:0] POS_SRC_1    = 8'd27;
    localparam logic [7:0] POS_SRC_2    = 8'd28;
    localparam logic [7:0] POS_SRC_3    = 8'd29;
    localparam logic [7:0] OFS_DOFF     = 8'd12;

    localparam logic [7:0] ETH_HDR_BYTES = 8'd14;
    localparam logic [7:0] MIN_FRAME_IP  = 8'd34;
    localparam logic [7:0] MIN_HDR_BYTES = 8'd20;
    localparam logic [7:0] UDP_HDR_BYTES = 8'd8;
    localparam logic [7:0] COUNT_MAX     = 8'd255;

    typedef struct packed {
        logic              hdr_ok;
        logic [ADDR_W-1:0] src_addr;
        logic [PORT_W-1:0] l4_port;
    } t_frame_info;

endpackage

// ----- rtl/psbf_in_if.sv -----
interface psbf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] rule_key;
    logic        rule_block;

    modport source (output valid, req_type, data_byte, last_byte, rule_key, rule_block,
                    input ready);
    modport sink   (input valid, req_type, data_byte, last_byte, rule_key, rule_block,
                    output ready);
endinterface

// ----- rtl/psbf_out_if.sv -----
interface psbf_out_if;
    logic valid;
    logic ready;
    logic result_kind;
    logic drop;
    logic write_ok;

    modport source (output valid, result_kind, drop, write_ok, input ready);
    modport sink   (input valid, result_kind, drop, write_ok, output ready);
endinterface

// ----- rtl/psbf_frame_parse.sv -----
module psbf_frame_parse (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    output psbf_pkg::t_frame_info  o_info
);

    logic [7:0]  r_byte_count, n_byte_count;
    logic [15:0] r_ether_type, n_ether_type;
    logic [3:0]  r_header_words, n_header_words;
    logic [7:0]  r_protocol, n_protocol;
    logic [31:0] r_src_addr, n_src_addr;
    logic [15:0] r_l4_port, n_l4_port;
    logic [3:0]  r_tcp_words, n_tcp_words;

    logic [7:0]  l_pos;
    logic [7:0]  ihl_bytes;
    logic [7:0]  doff_bytes;
    logic [7:0]  n_l_pos;
    logic        is_tcp;
    logic        is_udp;
    logic        ok_eth;
    logic        ok_ip;
    logic        ok_l4;

    // transport header start, from the IHL as it stands before this byte
    assign l_pos = psbf_pkg::ETH_HDR_BYTES + {2'b00, r_header_words, 2'b00};

    always_comb begin
        n_ether_type   = r_ether_type;
        n_header_words = r_header_words;
        n_protocol     = r_protocol;
        n_src_addr     = r_src_addr;
        n_l4_port      = r_l4_port;
        n_tcp_words    = r_tcp_words;
        n_byte_count   = (r_byte_count == psbf_pkg::COUNT_MAX) ? r_byte_count
                                                               : r_byte_count + 8'd1;
        case (r_byte_count)
            psbf_pkg::POS_ETYPE_HI: n_ether_type[15:8] = i_byte;
            psbf_pkg::POS_ETYPE_LO: n_ether_type[7:0]  = i_byte;
            psbf_pkg::POS_IHL:      n_header_words     = i_byte[3:0];
            psbf_pkg::POS_PROTO:    n_protocol         = i_byte;
            psbf_pkg::POS_SRC_0:    n_src_addr[31:24]  = i_byte;
            psbf_pkg::POS_SRC_1:    n_src_addr[23:16]  = i_byte;
            psbf_pkg::POS_SRC_2:    n_src_addr[15:8]   = i_byte;
            psbf_pkg::POS_SRC_3:    n_src_addr[7:0]    = i_byte;
            default: ;
        endcase
        if (r_byte_count == l_pos)
            n_l4_port[15:8] = i_byte;
        if (r_byte_count == l_pos + 8'd1)
            n_l4_port[7:0] = i_byte;
        if (r_byte_count == l_pos + psbf_pkg::OFS_DOFF)
            n_tcp_words = i_byte[7:4];
    end

    // frame checks on the state as it stands after this byte
    always_comb begin
        ihl_bytes  = {2'b00, n_header_words, 2'b00};
        doff_bytes = {2'b00, n_tcp_words, 2'b00};
        n_l_pos    = psbf_pkg::ETH_HDR_BYTES + ihl_bytes;
        is_tcp     = (n_protocol == psbf_pkg::PROTO_TCP);
        is_udp     = (n_protocol == psbf_pkg::PROTO_UDP);
        ok_eth     = (n_byte_count >= psbf_pkg::MIN_FRAME_IP)
                     && (n_ether_type == psbf_pkg::ETHERTYPE_IPV4);
        ok_ip      = (is_tcp || is_udp) && (ihl_bytes >= psbf_pkg::MIN_HDR_BYTES)
                     && (n_byte_count >= n_l_pos);
        if (is_tcp)
            ok_l4 = (n_byte_count >= n_l_pos + psbf_pkg::MIN_HDR_BYTES)
                    && (doff_bytes >= psbf_pkg::MIN_HDR_BYTES)
                    && (n_byte_count >= n_l_pos + doff_bytes);
        else
            ok_l4 = (n_byte_count >= n_l_pos + psbf_pkg::UDP_HDR_BYTES);
    end

    assign o_info.hdr_ok   = ok_eth && ok_ip && ok_l4;
    assign o_info.src_addr = n_src_addr;
    assign o_info.l4_port  = n_l4_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_ether_type   <= '0;
            r_header_words <= '0;
            r_protocol     <= '0;
            r_src_addr     <= '0;
            r_l4_port      <= '0;
            r_tcp_words    <= '0;
        end else if (i_step) begin
            if (i_last) begin
                // verdict given, start the next frame from scratch
                r_byte_count   <= '0;
                r_ether_type   <= '0;
                r_header_words <= '0;
                r_protocol     <= '0;
                r_src_addr     <= '0;
                r_l4_port      <= '0;
                r_tcp_words    <= '0;
            end else begin
                r_byte_count   <= n_byte_count;
                r_ether_type   <= n_ether_type;
                r_header_words <= n_header_words;
                r_protocol     <= n_protocol;
                r_src_addr     <= n_src_addr;
                r_l4_port      <= n_l4_port;
                r_tcp_words    <= n_tcp_words;
            end
        end
    end

endmodule

// ----- rtl/psbf_addr_cam.sv -----
module psbf_addr_cam #(
    parameter int unsigned SLOTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [psbf_pkg::ADDR_W-1:0] i_key,
    input  logic                        i_wr,
    input  logic                        i_block,
    output logic                        o_hit_block,
    output logic                        o_write_ok
);

    logic [SLOTS-1:0]                  r_valid;
    logic [SLOTS-1:0]                  r_block;
    logic [psbf_pkg::ADDR_W-1:0]       r_key [SLOTS];

    logic [SLOTS-1:0] match;
    logic [SLOTS-1:0] free;
    logic [SLOTS-1:0] first_free;
    logic             any_match;

    always_comb begin
        for (int s = 0; s < SLOTS; s++)
            match[s] = r_valid[s] && (r_key[s] == i_key);
    end

    assign any_match   = |match;
    assign free        = ~r_valid;
    // isolate the lowest free slot
    assign first_free  = free & (~free + {{(SLOTS-1){1'b0}}, 1'b1});
    assign o_hit_block = |(match & r_block);
    assign o_write_ok  = any_match || (|free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr && !any_match) begin
            r_valid <= r_valid | first_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (any_match) begin
                    if (match[s])
                        r_block[s] <= i_block;
                end else if (first_free[s]) begin
                    r_block[s] <= i_block;
                    r_key[s]   <= i_key;
                end
            end
        end
    end

endmodule

// ----- rtl/psbf_port_map.sv -----
module psbf_port_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [psbf_pkg::PORT_W-1:0] i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [psbf_pkg::PORT_W-1:0] i_wr_addr,
    input  logic                        i_wr_bit,
    output logic                        o_rd_bit,
    output logic                        o_busy
);

    logic                        r_mem [psbf_pkg::PORT_SPACE];
    logic                        r_rd_bit;
    logic                        r_busy;
    logic [psbf_pkg::PORT_W-1:0] r_clr_addr;

    // clearing sweep after reset, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr)
                r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy)
            r_mem[r_clr_addr] <= 1'b0;
        else if (i_wr_en)
            r_mem[i_wr_addr] <= i_wr_bit;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en)
            r_rd_bit <= r_mem[i_rd_addr];
    end

    assign o_rd_bit = r_rd_bit;
    assign o_busy   = r_busy;

endmodule

// ----- rtl/packet_source_blocklist_filter_unit.sv -----
// channel  | dir | handshake    | payload
// i_req    | in  | valid/ready  | req_type, data_byte, last_byte, rule_key, rule_block
// o_res    | out | valid/ready  | result_kind, drop, write_ok
//
// One item a cycle unless o_res stalls or the bitmap sweep runs. Three register
// stages: input, lookup (slot match and port bitmap read), result; each result passes
// all three before it leaves. After reset the port bitmap is swept clear, all 65536
// entries, with i_req.ready low. Each stage holds while the one after it is full and
// stalled; items that give no result leave no bubble.
module packet_source_blocklist_filter_unit #(
    parameter int unsigned ADDRESS_RULE_SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    psbf_in_if.sink           i_req,
    psbf_out_if.source        o_res
);

    // input stage
    logic        r_s1_valid;
    logic [1:0]  r_s1_req;
    logic [7:0]  r_s1_byte;
    logic        r_s1_last;
    logic [31:0] r_s1_key;
    logic        r_s1_block;

    // lookup stage
    logic        r_s2_valid;
    logic        r_s2_kind;
    logic        r_s2_hdr_ok;
    logic        r_s2_hit;
    logic        r_s2_wok;

    // result stage
    logic        r_o_valid;
    logic        r_o_kind;
    logic        r_o_drop;
    logic        r_o_wok;

    logic        out_free;
    logic        s2_free;
    logic        s1_free;
    logic        s1_go;
    logic        in_xfer;
    logic        busy;
    logic        is_byte;
    logic        is_addr;
    logic        is_port;
    logic        has_result;
    logic        cam_hit;
    logic        cam_wok;
    logic        port_bit;
    logic [31:0] cam_key;

    psbf_pkg::t_frame_info info;

    assign out_free = !r_o_valid || o_res.ready;
    assign s2_free  = !r_s2_valid || out_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign s1_go    = r_s1_valid && s2_free;

    assign i_req.ready = s1_free && !busy;
    assign in_xfer     = i_req.valid && i_req.ready;

    always_comb begin
        is_byte = 1'b0;
        is_addr = 1'b0;
        is_port = 1'b0;
        unique case (r_s1_req)
            psbf_pkg::REQ_BYTE:      is_byte = 1'b1;
            psbf_pkg::REQ_ADDR_RULE: is_addr = 1'b1;
            psbf_pkg::REQ_PORT_RULE: is_port = 1'b1;
            default: ;
        endcase
    end

    assign has_result = (is_byte && r_s1_last) || is_addr || is_port;
    assign cam_key    = is_addr ? r_s1_key : info.src_addr;

    psbf_frame_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_go && is_byte),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .o_info  (info)
    );

    psbf_addr_cam #(
        .SLOTS (ADDRESS_RULE_SLOTS)
    ) u_cam (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (cam_key),
        .i_wr        (s1_go && is_addr),
        .i_block     (r_s1_block),
        .o_hit_block (cam_hit),
        .o_write_ok  (cam_wok)
    );

    psbf_port_map u_ports (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s1_go),
        .i_rd_addr (info.l4_port),
        .i_wr_en   (s1_go && is_port),
        .i_wr_addr (r_s1_key[psbf_pkg::PORT_W-1:0]),
        .i_wr_bit  (r_s1_block),
        .o_rd_bit  (port_bit),
        .o_busy    (busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_req   <= i_req.req_type;
            r_s1_byte  <= i_req.data_byte;
            r_s1_last  <= i_req.last_byte;
            r_s1_key   <= i_req.rule_key;
            r_s1_block <= i_req.rule_block;
        end
    end

    // drop items that give no result here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= s1_go && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_kind   <= is_byte ? psbf_pkg::KIND_VERDICT : psbf_pkg::KIND_ACK;
            r_s2_hdr_ok <= info.hdr_ok;
            r_s2_hit    <= cam_hit;
            r_s2_wok    <= is_port || cam_wok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s2_valid) begin
            r_o_kind <= r_s2_kind;
            r_o_drop <= (r_s2_kind == psbf_pkg::KIND_VERDICT) && r_s2_hdr_ok
                        && (r_s2_hit || port_bit);
            r_o_wok  <= (r_s2_kind == psbf_pkg::KIND_ACK) && r_s2_wok;
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.result_kind = r_o_kind;
    assign o_res.drop        = r_o_drop;
    assign o_res.write_ok    = r_o_wok;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned SLOTS          = 64;
    localparam int unsigned WATCHDOG_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned PHASE_ITEMS    = 450;
    localparam int unsigned FILL_WRITES    = 70;
    localparam int unsigned POOL_SIZE      = 16;
    localparam logic [1:0]  REQ_UNUSED     = 2'd3;

    typedef struct packed {
        logic        kind;
        logic        drop;
        logic        ok;
    } t_response;

    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  data;
        logic        last;
        logic [31:0] key;
        logic        block;
    } t_request;

    typedef struct packed {
        t_request    rq;
        logic        typed;
        logic        has;
        t_response   resp;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    psbf_in_if  req_bus ();
    psbf_out_if res_bus ();

    packet_source_blocklist_filter_unit #(
        .ADDRESS_RULE_SLOTS(SLOTS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    // frame capture state of the predictor
    logic [7:0]  fr_count;
    logic [15:0] fr_etype;
    logic [3:0]  fr_ihl;
    logic [7:0]  fr_proto;
    logic [31:0] fr_saddr;
    logic [15:0] fr_sport;
    logic [3:0]  fr_doff;

    // rule stores of the predictor
    bit          slot_used   [SLOTS];
    bit          slot_blocks [SLOTS];
    logic [31:0] slot_addr   [SLOTS];
    bit          port_blocked_map [psbf_pkg::PORT_SPACE];

    t_response   awaited_responses [$];
    t_response   head_response;
    t_stim_row   directed_rows [$];

    logic [31:0] addr_pool [POOL_SIZE];
    logic [15:0] port_pool [POOL_SIZE];
    logic [7:0]  frame_buf [300];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned idle_cycles;
    int unsigned requests_sent;
    int unsigned frames_sent;
    int unsigned verdicts_seen;
    int unsigned drops_seen;
    int unsigned acks_seen;
    int unsigned refusals_seen;
    int unsigned mismatch_count;
    bit          timed_out;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endtask

    task automatic clear_frame_capture();
        fr_count = '0;
        fr_etype = '0;
        fr_ihl   = '0;
        fr_proto = '0;
        fr_saddr = '0;
        fr_sport = '0;
        fr_doff  = '0;
    endtask

    function automatic bit address_blocked(input logic [31:0] addr);
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_used[s] && slot_addr[s] == addr) begin
                return slot_blocks[s];
            end
        end
        return 1'b0;
    endfunction

    function automatic bit store_address_rule(input logic [31:0] addr, input logic block);
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_used[s] && slot_addr[s] == addr) begin
                slot_blocks[s] = block;
                return 1'b1;
            end
        end
        for (int s = 0; s < SLOTS; s++) begin
            if (!slot_used[s]) begin
                slot_used[s]   = 1'b1;
                slot_addr[s]   = addr;
                slot_blocks[s] = block;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // the port offset uses the IHL as it stands before this byte is taken
    task automatic absorb_byte(input logic [7:0] b);
        int pos;
        int l4;
        pos = int'(fr_count);
        l4  = int'(psbf_pkg::ETH_HDR_BYTES) + 4 * int'(fr_ihl);
        if (pos == int'(psbf_pkg::POS_ETYPE_HI)) fr_etype[15:8] = b;
        if (pos == int'(psbf_pkg::POS_ETYPE_LO)) fr_etype[7:0] = b;
        if (pos == int'(psbf_pkg::POS_IHL)) fr_ihl = b[3:0];
        if (pos == int'(psbf_pkg::POS_PROTO)) fr_proto = b;
        if (pos >= int'(psbf_pkg::POS_SRC_0) && pos <= int'(psbf_pkg::POS_SRC_3)) begin
            fr_saddr[8 * (int'(psbf_pkg::POS_SRC_3) - pos) +: 8] = b;
        end
        if (pos == l4) fr_sport[15:8] = b;
        if (pos == l4 + 1) fr_sport[7:0] = b;
        if (pos == l4 + int'(psbf_pkg::OFS_DOFF)) fr_doff = b[7:4];
    endtask

    function automatic bit frame_dropped(input int n);
        int hdr;
        int l4;
        int tcp_len;
        if (n < int'(psbf_pkg::ETH_HDR_BYTES) || fr_etype != psbf_pkg::ETHERTYPE_IPV4)
            return 1'b0;
        if (n < int'(psbf_pkg::MIN_FRAME_IP)) return 1'b0;
        if (fr_proto != psbf_pkg::PROTO_TCP && fr_proto != psbf_pkg::PROTO_UDP) return 1'b0;
        hdr = 4 * int'(fr_ihl);
        if (hdr < int'(psbf_pkg::MIN_HDR_BYTES) || n < int'(psbf_pkg::ETH_HDR_BYTES) + hdr)
            return 1'b0;
        l4 = int'(psbf_pkg::ETH_HDR_BYTES) + hdr;
        if (fr_proto == psbf_pkg::PROTO_TCP) begin
            tcp_len = 4 * int'(fr_doff);
            if (n < l4 + int'(psbf_pkg::MIN_HDR_BYTES)) return 1'b0;
            if (tcp_len < int'(psbf_pkg::MIN_HDR_BYTES) || n < l4 + tcp_len) return 1'b0;
        end else begin
            if (n < l4 + int'(psbf_pkg::UDP_HDR_BYTES)) return 1'b0;
        end
        return address_blocked(fr_saddr) || port_blocked_map[fr_sport];
    endfunction

    task automatic compute_response(input t_request rq, output bit has,
                                    output t_response resp);
        has  = 1'b0;
        resp = '0;
        case (rq.req)
            psbf_pkg::REQ_BYTE: begin
                absorb_byte(rq.data);
                if (fr_count != psbf_pkg::COUNT_MAX) fr_count = fr_count + 8'd1;
                if (rq.last) begin
                    has       = 1'b1;
                    resp.kind = psbf_pkg::KIND_VERDICT;
                    resp.drop = frame_dropped(int'(fr_count));
                    clear_frame_capture();
                end
            end
            psbf_pkg::REQ_ADDR_RULE: begin
                has       = 1'b1;
                resp.kind = psbf_pkg::KIND_ACK;
                resp.ok   = store_address_rule(rq.key, rq.block);
            end
            psbf_pkg::REQ_PORT_RULE: begin
                has       = 1'b1;
                resp.kind = psbf_pkg::KIND_ACK;
                resp.ok   = 1'b1;
                port_blocked_map[rq.key[15:0]] = rq.block;
            end
            default: has = 1'b0;
        endcase
    endtask

    // enter and leave at a falling edge; hold valid high across back-to-back transfers
    task automatic send_request(input t_request rq, input bit typed, input bit typed_has,
                                input t_response typed_resp);
        bit        has;
        t_response resp;
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid      = 1'b0;
            req_bus.req_type   = 2'($urandom);
            req_bus.data_byte  = 8'($urandom);
            req_bus.last_byte  = 1'($urandom);
            req_bus.rule_key   = $urandom;
            req_bus.rule_block = 1'($urandom);
            @(negedge i_clk);
        end
        req_bus.req_type   = rq.req;
        req_bus.data_byte  = rq.data;
        req_bus.last_byte  = rq.last;
        req_bus.rule_key   = rq.key;
        req_bus.rule_block = rq.block;
        req_bus.valid      = 1'b1;
        do @(posedge i_clk); while (!req_bus.ready);
        compute_response(rq, has, resp);
        if (typed) begin
            has  = typed_has;
            resp = typed_resp;
        end
        if (has) awaited_responses.push_back(resp);
        if (rq.req != REQ_UNUSED) requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [1:0] req, input logic [7:0] data, input logic last,
                           input logic [31:0] key, input logic block, input bit typed,
                           input bit has, input logic kind, input logic drop,
                           input logic ok);
        t_stim_row row;
        row.rq    = '{req: req, data: data, last: last, key: key, block: block};
        row.typed = typed;
        row.has   = has;
        row.resp  = '{kind: kind, drop: drop, ok: ok};
        directed_rows.push_back(row);
    endtask

    task automatic send_rule();
        t_request    rq;
        logic [15:0] upper;
        rq.data  = 8'($urandom);
        rq.last  = 1'($urandom);
        rq.block = ($urandom_range(99) < 65);
        upper    = 16'($urandom);
        if ($urandom_range(1)) begin
            rq.req = psbf_pkg::REQ_ADDR_RULE;
            if ($urandom_range(99) < 70) rq.key = addr_pool[$urandom_range(POOL_SIZE - 1)];
            else rq.key = $urandom;
        end else begin
            rq.req = psbf_pkg::REQ_PORT_RULE;
            rq.key = {upper, port_pool[$urandom_range(POOL_SIZE - 1)]};
            if ($urandom_range(99) < 40) rq.key[15:0] = 16'($urandom);
        end
        send_request(rq, 1'b0, 1'b0, '0);
    endtask

    // mostly well-formed IPv4 TCP/UDP frames with random content; some overlong, the rest broken
    task automatic build_frame(input bit force_long, output int len);
        int          variant;
        int          ihl;
        int          doff;
        int          l4;
        bit          is_tcp;
        logic [31:0] saddr;
        logic [15:0] sport;
        for (int i = 0; i < 300; i++) frame_buf[i] = 8'($urandom);
        variant = $urandom_range(99);
        if (variant >= 94 && variant < 98 && !force_long) begin
            len = $urandom_range(1, 60);
            return;
        end
        is_tcp = 1'($urandom_range(1));
        ihl    = ($urandom_range(3) == 0) ? $urandom_range(6, 15) : 5;
        doff   = ($urandom_range(3) == 0) ? $urandom_range(6, 15) : 5;
        if ($urandom_range(99) < 60) saddr = addr_pool[$urandom_range(POOL_SIZE - 1)];
        else saddr = $urandom;
        if ($urandom_range(99) < 60) sport = port_pool[$urandom_range(POOL_SIZE - 1)];
        else sport = 16'($urandom);
        l4  = int'(psbf_pkg::ETH_HDR_BYTES) + 4 * ihl;
        len = l4 + (is_tcp ? 4 * doff : int'(psbf_pkg::UDP_HDR_BYTES)) + $urandom_range(0, 12);
        frame_buf[psbf_pkg::POS_ETYPE_HI] = psbf_pkg::ETHERTYPE_IPV4[15:8];
        frame_buf[psbf_pkg::POS_ETYPE_LO] = psbf_pkg::ETHERTYPE_IPV4[7:0];
        frame_buf[psbf_pkg::POS_IHL]      = {4'h4, 4'(ihl)};
        frame_buf[psbf_pkg::POS_PROTO]    = is_tcp ? psbf_pkg::PROTO_TCP : psbf_pkg::PROTO_UDP;
        frame_buf[psbf_pkg::POS_SRC_0]    = saddr[31:24];
        frame_buf[psbf_pkg::POS_SRC_1]    = saddr[23:16];
        frame_buf[psbf_pkg::POS_SRC_2]    = saddr[15:8];
        frame_buf[psbf_pkg::POS_SRC_3]    = saddr[7:0];
        frame_buf[l4]                     = sport[15:8];
        frame_buf[l4 + 1]                 = sport[7:0];
        if (is_tcp) frame_buf[l4 + psbf_pkg::OFS_DOFF][7:4] = 4'(doff);
        if (force_long || variant >= 98) begin
            len = $urandom_range(256, 270);
        end else if (variant >= 70 && variant < 76) begin
            len = $urandom_range(1, len - 1);
        end else if (variant >= 76 && variant < 81) begin
            frame_buf[psbf_pkg::POS_ETYPE_LO] = 8'($urandom_range(1, 255));
        end else if (variant >= 81 && variant < 86) begin
            frame_buf[psbf_pkg::POS_PROTO] = 8'($urandom);
        end else if (variant >= 86 && variant < 90) begin
            frame_buf[psbf_pkg::POS_IHL][3:0] = 4'($urandom_range(0, 4));
        end else if (variant >= 90 && variant < 94) begin
            frame_buf[l4 + psbf_pkg::OFS_DOFF][7:4] = 4'($urandom_range(0, 4));
        end
    endtask

    task automatic send_frame(input bit force_long);
        int       len;
        t_request rq;
        build_frame(force_long, len);
        for (int i = 0; i < len; i++) begin
            // slip a rule write in between bytes now and then
            if (i > 0 && $urandom_range(99) < 3) send_rule();
            rq.req   = psbf_pkg::REQ_BYTE;
            rq.data  = frame_buf[i];
            rq.last  = (i == len - 1);
            rq.key   = $urandom;
            rq.block = 1'($urandom);
            send_request(rq, 1'b0, 1'b0, '0);
        end
        frames_sent++;
    endtask

    task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                             input bit with_long, input bit with_fill);
        int unsigned start;
        int unsigned pick;
        t_request    rq;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start         = requests_sent;
        if (with_long) send_frame(1'b1);
        if (with_fill) begin
            // fresh keys: run the address table out of slots
            repeat (FILL_WRITES) begin
                rq = '{req: psbf_pkg::REQ_ADDR_RULE, data: 8'($urandom),
                       last: 1'($urandom), key: $urandom, block: 1'($urandom)};
                send_request(rq, 1'b0, 1'b0, '0);
            end
        end
        while (requests_sent - start < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                send_frame(1'b0);
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 6)) send_rule();
            end else begin
                rq = '{req: REQ_UNUSED, data: 8'($urandom), last: 1'($urandom),
                       key: $urandom, block: 1'($urandom)};
                send_request(rq, 1'b0, 1'b0, '0);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (awaited_responses.size() == 0) begin
                report_mismatch("result transfer with nothing awaited");
            end else begin
                head_response = awaited_responses.pop_front();
                if (res_bus.result_kind !== head_response.kind) begin
                    report_mismatch($sformatf("result_kind %b, expected %b",
                                              res_bus.result_kind, head_response.kind));
                end
                if (res_bus.drop !== head_response.drop) begin
                    report_mismatch($sformatf("drop %b, expected %b",
                                              res_bus.drop, head_response.drop));
                end
                if (res_bus.write_ok !== head_response.ok) begin
                    report_mismatch($sformatf("write_ok %b, expected %b",
                                              res_bus.write_ok, head_response.ok));
                end
            end
            if (res_bus.result_kind == psbf_pkg::KIND_VERDICT) begin
                verdicts_seen++;
                if (res_bus.drop) drops_seen++;
            end else begin
                acks_seen++;
                if (!res_bus.write_ok) refusals_seen++;
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = psbf_pkg::REQ_BYTE;
        req_bus.data_byte  = '0;
        req_bus.last_byte  = 1'b0;
        req_bus.rule_key   = '0;
        req_bus.rule_block = 1'b0;
        res_bus.ready      = 1'b0;
        send_idle_pct      = 33;
        recv_idle_pct      = 52;
        idle_cycles        = 0;
        requests_sent      = 0;
        frames_sent        = 0;
        verdicts_seen      = 0;
        drops_seen         = 0;
        acks_seen          = 0;
        refusals_seen      = 0;
        mismatch_count     = 0;
        timed_out          = 1'b0;
        clear_frame_capture();
        for (int s = 0; s < SLOTS; s++) begin
            slot_used[s]   = 1'b0;
            slot_blocks[s] = 1'b0;
            slot_addr[s]   = '0;
        end
        for (int p = 0; p < psbf_pkg::PORT_SPACE; p++) port_blocked_map[p] = 1'b0;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        for (int k = 2; k < POOL_SIZE; k++) begin
            addr_pool[k] = $urandom;
            port_pool[k] = 16'($urandom);
        end

        // single-item frames, rule extremes, ignored requests, writes inside a frame
        add_row(psbf_pkg::REQ_BYTE, 8'h00, 1'b1, 32'h0, 1'b0,
                1'b1, 1'b1, psbf_pkg::KIND_VERDICT, 1'b0, 1'b0);
        add_row(psbf_pkg::REQ_BYTE, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
                1'b1, 1'b1, psbf_pkg::KIND_VERDICT, 1'b0, 1'b0);
        add_row(psbf_pkg::REQ_ADDR_RULE, 8'h00, 1'b0, 32'hFFFF_FFFF, 1'b1,
                1'b1, 1'b1, psbf_pkg::KIND_ACK, 1'b0, 1'b1);
        add_row(psbf_pkg::REQ_ADDR_RULE, 8'hFF, 1'b1, 32'h0000_0000, 1'b0,
                1'b1, 1'b1, psbf_pkg::KIND_ACK, 1'b0, 1'b1);
        add_row(psbf_pkg::REQ_ADDR_RULE, 8'h00, 1'b0, 32'hFFFF_FFFF, 1'b0,
                1'b1, 1'b1, psbf_pkg::KIND_ACK, 1'b0, 1'b1);
        add_row(psbf_pkg::REQ_ADDR_RULE, 8'h5A, 1'b0, 32'h5555_AAAA, 1'b1,
                1'b0, 1'b0, psbf_pkg::KIND_ACK, 1'b0, 1'b0);
        add_row(psbf_pkg::REQ_PORT_RULE, 8'h00, 1'b0, 32'hFFFF_0000, 1'b1,
                1'b1, 1'b1, psbf_pkg::KIND_ACK, 1'b0, 1'b1);
        add_row(psbf_pkg::REQ_PORT_RULE, 8'h00, 1'b1, 32'h0000_FFFF, 1'b1,
                1'b1, 1'b1, psbf_pkg::KIND_ACK, 1'b0, 1'b1);
        add_row(psbf_pkg::REQ_PORT_RULE, 8'hFF, 1'b0, 32'h0000_FFFF, 1'b0,
                1'b1, 1'b1, psbf_pkg::KIND_ACK, 1'b0, 1'b1);
        add_row(REQ_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
                1'b1, 1'b0, psbf_pkg::KIND_VERDICT, 1'b0, 1'b0);
        add_row(REQ_UNUSED, 8'h00, 1'b0, 32'h0000_0000, 1'b0,
                1'b1, 1'b0, psbf_pkg::KIND_VERDICT, 1'b0, 1'b0);
        add_row(psbf_pkg::REQ_BYTE, 8'h12, 1'b0, 32'h0, 1'b0,
                1'b1, 1'b0, psbf_pkg::KIND_VERDICT, 1'b0, 1'b0);
        add_row(psbf_pkg::REQ_ADDR_RULE, 8'h00, 1'b0, 32'hC0A8_0001, 1'b1,
                1'b1, 1'b1, psbf_pkg::KIND_ACK, 1'b0, 1'b1);
        add_row(psbf_pkg::REQ_PORT_RULE, 8'h00, 1'b0, 32'h0000_1234, 1'b1,
                1'b1, 1'b1, psbf_pkg::KIND_ACK, 1'b0, 1'b1);
        add_row(psbf_pkg::REQ_BYTE, 8'h34, 1'b1, 32'h0, 1'b0,
                1'b1, 1'b1, psbf_pkg::KIND_VERDICT, 1'b0, 1'b0);
        add_row(psbf_pkg::REQ_BYTE, 8'hAA, 1'b0, 32'h0, 1'b0,
                1'b1, 1'b0, psbf_pkg::KIND_VERDICT, 1'b0, 1'b0);
        add_row(psbf_pkg::REQ_BYTE, 8'h55, 1'b1, 32'h0, 1'b0,
                1'b1, 1'b1, psbf_pkg::KIND_VERDICT, 1'b0, 1'b0);

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        fork
            begin
                for (int r = 0; r < directed_rows.size(); r++) begin
                    send_request(directed_rows[r].rq, directed_rows[r].typed,
                                 directed_rows[r].has, directed_rows[r].resp);
                end
                run_phase(33, 52, 1'b1, 1'b0);
                run_phase(52, 33, 1'b0, 1'b1);
                run_phase(0, 0, 1'b0, 1'b0);
                req_bus.valid = 1'b0;
                while (awaited_responses.size() != 0) @(posedge i_clk);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        disable fork;

        if (timed_out) begin
            $display("Stalled for %0d cycles with %0d results outstanding",
                     idle_cycles, awaited_responses.size());
            $display("CHECKS FAILED");
        end else begin
            $display("Sent %0d requests including %0d frames; saw %0d verdicts (%0d drops)",
                     requests_sent, frames_sent, verdicts_seen, drops_seen);
            $display("and %0d rule acknowledgements (%0d refused), %0d mismatches",
                     acks_seen, refusals_seen, mismatch_count);
            if (mismatch_count == 0) begin
                $display("ALL CHECKS PASSED");
            end else begin
                $display("CHECKS FAILED");
            end
        end
        $finish;
    end

endmodule
